// ===== design/stps_pkg.sv =====
// Shared constants and types for the moving-average position signal block.
`timescale 1ns / 1ps
`default_nettype none

package stps_pkg;

    // Ring of past samples
    localparam int RING_DEPTH = 64;
    localparam int RING_AW    = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;

    // Field widths
    localparam int PRICE_W = 48;
    localparam int SUM_W   = 54;
    localparam int LEN_W   = 7;
    localparam int LIMIT_W = 4;
    localparam int POS_W   = 4;
    localparam int SCALE_W = PRICE_W + LEN_W;

    // Stream word widths
    localparam int S_DATA_W = 56;
    localparam int M_DATA_W = 64;

    // Window length cap: the smaller of the ring depth and 64
    localparam int WIN_MAX = 64;
    localparam int WIN_CAP = (RING_DEPTH < WIN_MAX) ? RING_DEPTH : WIN_MAX;

    // Index arithmetic width: holds values below twice the ring depth and any length
    localparam int IDX_W = ((RING_AW + 1) > LEN_W) ? (RING_AW + 1) : LEN_W;

    // Register indexes
    localparam logic REG_WINDOW_LENGTH  = 1'b0;
    localparam logic REG_POSITION_LIMIT = 1'b1;

    // Reset values of the registers
    localparam logic [LEN_W-1:0]   WINDOW_LENGTH_RST  = 7'd1;
    localparam logic [LIMIT_W-1:0] POSITION_LIMIT_RST = 4'd4;

    // Decision codes
    typedef enum logic [1:0] {
        ACT_NONE = 2'd0,
        ACT_BUY  = 2'd1,
        ACT_SELL = 2'd2
    } t_action;

endpackage

`default_nettype wire

// ===== design/stps_ram.sv =====
// Generic simple dual-port RAM with registered read (read-first on collision).
`timescale 1ns / 1ps
`default_nettype none

module stps_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Read returns the old contents when the same entry is written
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== design/sma_threshold_position_signal.sv =====
// Top level: moving-average threshold buy/sell signal with a ring of past prices.
`timescale 1ns / 1ps
`default_nettype none

// One price word per clock is accepted and one result word per clock leaves
// while the result side keeps taking words; an accepted word passes through
// the stage-1 registers into the output register. The accept stage writes the
// sample into the price ring and, in the same cycle on the RAM read port,
// fetches the entry that drops out of the window; it also forms price * length
// on the single 48x7 multiplier. The second stage updates the running sum and
// the position and decides; its result waits in the output register, and the
// input side keeps accepting as long as that register is free or being taken.
// The ring needs no clearing after reset: only entries written since reset
// or the last window_length write are ever read. Writing window_length clears
// the fill count and the sum; the ring and its write pointer keep their
// contents.
module sma_threshold_position_signal
    import stps_pkg::*;
(
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    // Input stream
    input  wire logic                s_axis_tvalid,
    output logic                     s_axis_tready,
    // [47:0] price, [48] buy_allowed, [49] sell_allowed, [55:50] zero
    input  wire logic [S_DATA_W-1:0] s_axis_tdata,
    // Result stream
    output logic                     m_axis_tvalid,
    input  wire logic                m_axis_tready,
    // [1:0] action, [55:2] window_total, [56] average_ready,
    // [60:57] position_count, [63:61] zero
    output logic      [M_DATA_W-1:0] m_axis_tdata,
    // Configuration writes
    input  wire logic                i_cfg_we,
    input  wire logic                i_cfg_index,
    input  wire logic [LEN_W-1:0]    i_cfg_data
);

    // Registers
    logic [LEN_W-1:0]   r_window_length;
    logic [LIMIT_W-1:0] r_position_limit;
    logic [SUM_W-1:0]   r_sum,  n_sum;
    logic [LEN_W-1:0]   r_fill, n_fill;
    logic [RING_AW-1:0] r_wp,   n_wp;
    logic [POS_W-1:0]   r_pos,  n_pos;

    // Stage 1 (after accept)
    logic               r_s1_valid;
    logic [PRICE_W-1:0] r_s1_price;
    logic               r_s1_buy;
    logic               r_s1_sell;
    logic               r_s1_ready;
    logic [SCALE_W-1:0] r_s1_scaled;

    // Output register
    logic               r_m_valid;
    logic [1:0]         r_m_action;
    logic [SUM_W-1:0]   r_m_total;
    logic               r_m_ready;
    logic [POS_W-1:0]   r_m_pos;

    logic               w_accept;
    logic               w_s2_fire;
    logic               w_cfg_len;
    logic               w_cfg_limit;
    logic [LEN_W-1:0]   w_len;
    logic [IDX_W-1:0]   w_idx_raw;
    logic [IDX_W-1:0]   w_idx;
    logic [RING_AW-1:0] w_old_addr;
    logic [PRICE_W-1:0] w_in_price;
    logic [PRICE_W-1:0] w_old_price;
    logic               w_ready;
    t_action            n_action;
    logic [SUM_W-1:0]   n_total;

    assign w_in_price  = s_axis_tdata[PRICE_W-1:0];
    assign w_cfg_len   = i_cfg_we && (i_cfg_index == REG_WINDOW_LENGTH);
    assign w_cfg_limit = i_cfg_we && (i_cfg_index == REG_POSITION_LIMIT);

    // Handshake: stage 2 drains into a free or emptying output register
    assign w_s2_fire     = r_s1_valid && (!r_m_valid || m_axis_tready);
    assign s_axis_tready = !r_s1_valid || w_s2_fire;
    assign w_accept      = s_axis_tvalid && s_axis_tready;

    // Effective window length
    always_comb begin
        if (r_window_length == '0) begin
            w_len = LEN_W'(1);
        end else if (r_window_length > LEN_W'(WIN_CAP)) begin
            w_len = LEN_W'(WIN_CAP);
        end else begin
            w_len = r_window_length;
        end
    end

    // Ring index of the sample leaving the window: wp - len modulo depth
    always_comb begin
        w_idx_raw = IDX_W'(r_wp) + IDX_W'(RING_DEPTH) - IDX_W'(w_len);
        if (w_idx_raw >= IDX_W'(RING_DEPTH)) begin
            w_idx = w_idx_raw - IDX_W'(RING_DEPTH);
        end else begin
            w_idx = w_idx_raw;
        end
        w_old_addr = w_idx[RING_AW-1:0];
    end

    assign w_ready = (r_fill >= w_len);

    // Fill count and write pointer advance at accept
    always_comb begin
        n_fill = r_fill;
        n_wp   = r_wp;
        if (w_accept) begin
            n_fill = w_ready ? w_len : r_fill + LEN_W'(1);
            if (r_wp == RING_AW'(RING_DEPTH - 1)) begin
                n_wp = '0;
            end else begin
                n_wp = r_wp + RING_AW'(1);
            end
        end
    end

    // Price ring: write new sample, read outgoing sample in the same cycle
    stps_ram #(
        .WIDTH (PRICE_W),
        .DEPTH (RING_DEPTH)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (w_accept),
        .i_waddr (r_wp),
        .i_wdata (w_in_price),
        .i_re    (w_accept),
        .i_raddr (w_old_addr),
        .o_rdata (w_old_price)
    );

    // Stage 2: decision, position and window sum
    always_comb begin
        n_action = ACT_NONE;
        n_total  = '0;
        n_pos    = r_pos;
        if (r_s1_ready) begin
            n_total = r_sum;
            n_sum   = r_sum - SUM_W'(w_old_price) + SUM_W'(r_s1_price);
            if (r_s1_scaled >= SCALE_W'(r_sum)) begin
                if ((r_pos < r_position_limit) && r_s1_buy) begin
                    n_action = ACT_BUY;
                    n_pos    = r_pos + POS_W'(1);
                end
            end else if ((r_pos != '0) && r_s1_sell) begin
                n_action = ACT_SELL;
                n_pos    = r_pos - POS_W'(1);
            end
        end else begin
            n_sum = r_sum + SUM_W'(r_s1_price);
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window_length  <= WINDOW_LENGTH_RST;
            r_position_limit <= POSITION_LIMIT_RST;
            r_sum            <= '0;
            r_fill           <= '0;
            r_wp             <= '0;
            r_pos            <= '0;
            r_s1_valid       <= 1'b0;
            r_m_valid        <= 1'b0;
        end else begin
            r_wp <= n_wp;
            if (w_cfg_len) begin
                r_window_length <= i_cfg_data;
                r_fill          <= '0;
                r_sum           <= '0;
            end else begin
                r_fill <= n_fill;
                if (w_s2_fire) begin
                    r_sum <= n_sum;
                end
            end
            if (w_cfg_limit) begin
                r_position_limit <= i_cfg_data[LIMIT_W-1:0];
            end
            if (w_s2_fire) begin
                r_pos <= n_pos;
            end
            if (w_accept) begin
                r_s1_valid <= 1'b1;
            end else if (w_s2_fire) begin
                r_s1_valid <= 1'b0;
            end
            if (w_s2_fire) begin
                r_m_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_s1_price  <= w_in_price;
            r_s1_buy    <= s_axis_tdata[PRICE_W];
            r_s1_sell   <= s_axis_tdata[PRICE_W+1];
            r_s1_ready  <= w_ready;
            r_s1_scaled <= SCALE_W'(w_in_price) * SCALE_W'(w_len);
        end
        if (w_s2_fire) begin
            r_m_action <= n_action;
            r_m_total  <= n_total;
            r_m_ready  <= r_s1_ready;
            r_m_pos    <= n_pos;
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = {3'b000, r_m_pos, r_m_ready, r_m_total, r_m_action};

    // Checks
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= w_len)
        else $error("fill count above window length");

    a_ring_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !w_s2_fire && !w_accept) |=> $stable(w_old_price))
        else $error("ring read data changed while stage 1 stalled");

    a_not_ready_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_m_valid && !r_m_ready) |-> (r_m_action == ACT_NONE && r_m_total == '0))
        else $error("decision made before window filled");

    a_buy_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_s2_fire && n_action == ACT_BUY) |=> (r_pos == $past(r_pos) + POS_W'(1)))
        else $error("buy did not raise position by one");

    a_sell_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_s2_fire && n_action == ACT_SELL) |=> (r_pos == $past(r_pos) - POS_W'(1)))
        else $error("sell did not lower position by one");

endmodule

`default_nettype wire

// ===== tb/tb_sma_threshold_position_signal.sv =====
// Testbench for the moving-average threshold position signal with a scoreboard predictor.
`timescale 1ns / 1ps

module tb_sma_threshold_position_signal;
    import stps_pkg::*;

    localparam int  CLK_HALF_NS  = 6;
    localparam int  RST_CYCLES   = 3;
    localparam int  IDLE_PCT     = 9;
    localparam int  SETTLE_CYC   = 4;
    localparam int  RANDOM_ITEMS = 1300;
    localparam real TIMEOUT_NS   = 300000.0 * 12.0;
    localparam logic [PRICE_W-1:0] PRICE_MAX = {PRICE_W{1'b1}};

    // Expected decision for one price word
    typedef struct {
        t_action            act;
        logic [SUM_W-1:0]   total;
        logic               ready;
        logic [POS_W-1:0]   pos;
    } t_decision;

    // Predictor and expected-decision store
    class position_scoreboard;
        logic [PRICE_W-1:0] price_hist [RING_DEPTH];
        logic [SUM_W-1:0]   window_sum;
        int                 fill;
        int                 wr_ptr;
        logic [POS_W-1:0]   pos;
        logic [LEN_W-1:0]   win_len;
        logic [LIMIT_W-1:0] pos_limit;
        t_decision          decisions_q [$];
        int                 errors;

        function new();
            foreach (price_hist[i]) price_hist[i] = '0;
            window_sum = '0;
            fill       = 0;
            wr_ptr     = 0;
            pos        = '0;
            win_len    = WINDOW_LENGTH_RST;
            pos_limit  = POSITION_LIMIT_RST;
            errors     = 0;
        endfunction

        // Register write; a length write restarts the window
        function void write_reg(logic idx, logic [LEN_W-1:0] data);
            if (idx == REG_WINDOW_LENGTH) begin
                win_len    = data;
                fill       = 0;
                window_sum = '0;
            end else begin
                pos_limit = data[LIMIT_W-1:0];
            end
        endfunction

        // Accepted price word: decide, then slide the window
        function void note_input(logic [PRICE_W-1:0] price, logic buy_ok, logic sell_ok);
            int          len;
            int          old_idx;
            logic [63:0] scaled;
            t_decision   d;
            len = int'(win_len);
            if (len == 0) len = 1;
            if (len > WIN_CAP) len = WIN_CAP;
            d.act   = ACT_NONE;
            d.total = '0;
            d.ready = 1'b0;
            if (fill >= len) begin
                scaled  = 64'(price) * 64'(len);
                d.ready = 1'b1;
                d.total = window_sum;
                if (scaled >= 64'(window_sum)) begin
                    if (pos < pos_limit && buy_ok) begin
                        d.act = ACT_BUY;
                        pos   = pos + 1'b1;
                    end
                end else if (pos > 0 && sell_ok) begin
                    d.act = ACT_SELL;
                    pos   = pos - 1'b1;
                end
                old_idx    = (wr_ptr + RING_DEPTH - len) % RING_DEPTH;
                window_sum = window_sum - SUM_W'(price_hist[old_idx]) + SUM_W'(price);
                fill       = len;
            end else begin
                window_sum = window_sum + SUM_W'(price);
                fill       = fill + 1;
            end
            price_hist[wr_ptr] = price;
            wr_ptr             = (wr_ptr + 1) % RING_DEPTH;
            d.pos              = pos;
            decisions_q.insert(decisions_q.size(), d);
        endfunction

        // Result word against the oldest expected decision
        function void check_result(logic [M_DATA_W-1:0] word);
            t_decision d;
            if (decisions_q.size() == 0) begin
                $error("result word 0x%h with no decision pending", word);
                errors++;
                return;
            end
            d = decisions_q.pop_front();
            if (word[1:0] !== d.act) begin
                $error("action: expected %0d, got %0d", d.act, word[1:0]);
                errors++;
            end
            if (word[55:2] !== d.total) begin
                $error("window_total: expected %0d, got %0d", d.total, word[55:2]);
                errors++;
            end
            if (word[56] !== d.ready) begin
                $error("average_ready: expected %0d, got %0d", d.ready, word[56]);
                errors++;
            end
            if (word[60:57] !== d.pos) begin
                $error("position_count: expected %0d, got %0d", d.pos, word[60:57]);
                errors++;
            end
        endfunction

        function int outstanding();
            return decisions_q.size();
        endfunction
    endclass

    logic                i_clk         = 1'b0;
    logic                i_rst_n       = 1'b0;
    logic                s_axis_tvalid = 1'b0;
    logic                s_axis_tready;
    logic [S_DATA_W-1:0] s_axis_tdata  = '0;
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    logic [M_DATA_W-1:0] m_axis_tdata;
    logic                i_cfg_we      = 1'b0;
    logic                i_cfg_index   = 1'b0;
    logic [LEN_W-1:0]    i_cfg_data    = '0;

    bit                  idle_on       = 1'b1;
    position_scoreboard  sb;
    logic [PRICE_W-1:0]  level;
    logic [PRICE_W-1:0]  prev_price;

    sma_threshold_position_signal uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    // Clock
    always begin
        #CLK_HALF_NS i_clk = 1'b1;
        #CLK_HALF_NS i_clk = 1'b0;
    end

    // Result side: random back-pressure, check every taken word
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
        m_axis_tready <= !idle_on || ($urandom_range(99) >= IDLE_PCT);
    end

    // Send one price word, with a random gap ahead of it
    task automatic send_price(logic [PRICE_W-1:0] price, logic buy_ok, logic sell_ok);
        while (idle_on && $urandom_range(99) < IDLE_PCT) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {6'b0, sell_ok, buy_ok, price};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        sb.note_input(price, buy_ok, sell_ok);
        prev_price = price;
    endtask

    // Hold the input until every pending decision has come out
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (sb.outstanding() != 0) @(posedge i_clk);
        repeat (SETTLE_CYC) @(posedge i_clk);
    endtask

    // Register write, only with the block idle
    task automatic write_cfg(logic idx, logic [LEN_W-1:0] data);
        wait_drained();
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        sb.write_reg(idx, data);
        i_cfg_we    <= 1'b0;
    endtask

    // Next random price: mostly a walk around a level, with flats and extremes
    function automatic logic [PRICE_W-1:0] pick_price();
        int                 r;
        logic [PRICE_W-1:0] step;
        r = $urandom_range(99);
        if (r < 8) return PRICE_W'({$urandom, $urandom});
        if (r < 12) return PRICE_MAX;
        if (r < 15) return '0;
        if (r < 40) return prev_price;
        step = PRICE_W'($urandom_range(1 << 20));
        if ($urandom_range(1)) begin
            if (level <= PRICE_MAX - step) level = level + step;
        end else if (level >= step) begin
            level = level - step;
        end
        return level;
    endfunction

    // Timeout
    initial begin
        #TIMEOUT_NS;
        $display("Mismatches found");
        $finish;
    end

    // Stimulus
    initial begin
        int               sent;
        int               phase;
        int               n_items;
        int               eff;
        logic [LEN_W-1:0] wl;

        sb         = new();
        level      = PRICE_W'({$urandom, $urandom}) >> 2;
        prev_price = level;
        repeat (RST_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: reset settings, length one
        send_price(48'd100, 1'b1, 1'b1);      // not ready yet
        send_price(48'd100, 1'b1, 1'b1);      // equal to mean: buy
        send_price(PRICE_MAX, 1'b1, 1'b1);
        send_price(48'd0, 1'b1, 1'b1);        // below mean: sell
        send_price(48'd0, 1'b0, 1'b1);        // equal, buying barred
        send_price(PRICE_MAX, 1'b1, 1'b0);
        send_price(PRICE_MAX, 1'b1, 1'b0);
        send_price(PRICE_MAX, 1'b1, 1'b0);
        send_price(PRICE_MAX, 1'b1, 1'b1);    // at the limit: no buy
        // Limit dropped below the position; upper data bits ignored
        write_cfg(REG_POSITION_LIMIT, 7'h70);
        send_price(PRICE_MAX, 1'b1, 1'b1);
        send_price(48'd1, 1'b1, 1'b0);        // below, selling barred
        send_price(48'd1, 1'b1, 1'b1);
        send_price(48'd0, 1'b1, 1'b1);
        write_cfg(REG_POSITION_LIMIT, 7'd15);
        // Length zero acts as one
        write_cfg(REG_WINDOW_LENGTH, 7'd0);
        send_price(48'd5, 1'b1, 1'b1);
        send_price(48'd4, 1'b1, 1'b1);
        send_price(48'd4, 1'b0, 1'b0);
        // Rewriting the same length still restarts the window
        write_cfg(REG_WINDOW_LENGTH, 7'd1);
        send_price(48'd7, 1'b1, 1'b1);
        send_price(48'd8, 1'b1, 1'b1);
        write_cfg(REG_WINDOW_LENGTH, 7'd2);
        send_price(48'd10, 1'b1, 1'b1);
        send_price(48'd20, 1'b1, 1'b1);
        send_price(48'd15, 1'b1, 1'b1);       // 2*15 equals the sum
        send_price(48'd14, 1'b1, 1'b1);

        // Random phases, each with its own settings
        sent  = 0;
        phase = 0;
        while (sent < RANDOM_ITEMS) begin
            case ($urandom_range(9))
                0:       wl = 7'd0;
                1:       wl = 7'd127;
                2:       wl = 7'd64;
                3:       wl = LEN_W'($urandom_range(126, 65));
                4:       wl = LEN_W'($urandom_range(63, 13));
                default: wl = LEN_W'($urandom_range(12, 1));
            endcase
            if (phase == 0) wl = 7'd127;
            write_cfg(REG_WINDOW_LENGTH, wl);
            if (phase == 1) write_cfg(REG_POSITION_LIMIT, 7'd0);
            else if ($urandom_range(9) < 7) write_cfg(REG_POSITION_LIMIT, LEN_W'($urandom));
            eff = (wl == 0) ? 1 : ((wl > WIN_CAP) ? WIN_CAP : int'(wl));
            n_items = eff + $urandom_range(120, 40);
            // A stretch with no idling on either side
            idle_on = !(phase == 3 || phase == 4);
            repeat (n_items) begin
                send_price(pick_price(), $urandom_range(9) < 7, $urandom_range(9) < 7);
                sent++;
                if ($urandom_range(199) == 0 || (phase == 2 && sent % 50 == 0))
                    wait_drained();
            end
            phase++;
        end

        idle_on = 1'b1;
        wait_drained();
        repeat (10) @(posedge i_clk);
        if (sb.errors == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
